// ===== rtl/moi_pkg.sv =====
// Shared types, constants and tables of the mecanum odometry integrator.
// Used by the arithmetic units and the top level.
package moi_pkg;

    localparam int unsigned ACC_W = 64;
    localparam int unsigned OPB_W = 36;
    localparam int unsigned CNT_W = 6;

    // Angle scale: 2^36 / (2000 * pi), rounded.
    localparam logic [23:0] ANGLE_GAIN = 24'd10937044;
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    // Reciprocal of 125 as ceil(2^40 / 125); exact for dividends below 2^33.
    localparam logic [33:0] RECIP_125 = 34'd8796093023;

    // Operand bit counts of the serial unit.
    localparam logic [CNT_W-1:0] NB_COEF = 6'd16;
    localparam logic [CNT_W-1:0] NB_PERIOD = 6'd10;
    localparam logic [CNT_W-1:0] NB_GAIN = 6'd24;
    localparam logic [CNT_W-1:0] NB_VEL = 6'd24;
    localparam logic [CNT_W-1:0] NB_RECIP = 6'd34;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_INV_BASE = 2'd1;
    localparam logic [1:0] CFG_PERIOD = 2'd2;

    typedef struct packed {
        logic                start;
        logic                b_signed;
        logic                sub;
        logic                keep;
        logic [CNT_W-1:0]    nbits;
    } t_mac_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_status;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_VX,
        ST_VY,
        ST_S3R,
        ST_WZ,
        ST_WZP,
        ST_DH,
        ST_CORD,
        ST_GXC,
        ST_GXS,
        ST_GXP,
        ST_GXD,
        ST_GYS,
        ST_GYC,
        ST_GYP,
        ST_GYD,
        ST_OUT
    } t_state;

    // Arctangent of 2^-i as a binary angle, 2^32 per turn.
    function automatic logic [31:0] atan_entry(input logic [3:0] idx);
        logic [31:0] v;
        unique case (idx)
            4'd0:  v = 32'd536870912;
            4'd1:  v = 32'd316933406;
            4'd2:  v = 32'd167458907;
            4'd3:  v = 32'd85004756;
            4'd4:  v = 32'd42667331;
            4'd5:  v = 32'd21354465;
            4'd6:  v = 32'd10679838;
            4'd7:  v = 32'd5340245;
            4'd8:  v = 32'd2670163;
            4'd9:  v = 32'd1335087;
            4'd10: v = 32'd667544;
            4'd11: v = 32'd333772;
            4'd12: v = 32'd166886;
            4'd13: v = 32'd83443;
            4'd14: v = 32'd41722;
            4'd15: v = 32'd20861;
        endcase
        return v;
    endfunction

    // Clamp a signed value to 16 bits.
    function automatic logic [15:0] sat16(input logic signed [31:0] v);
        logic [15:0] r;
        if (v > 32'sd32767) begin
            r = 16'h7FFF;
        end else if (v < -32'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/moi_item_if.sv =====
// Input channel of the odometry integrator: four wheel speeds per transaction.
// Depends on nothing.
interface moi_item_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] speed_front_left;
    logic signed [15:0] speed_front_right;
    logic signed [15:0] speed_back_left;
    logic signed [15:0] speed_back_right;

    modport source (
        output valid, speed_front_left, speed_front_right,
        output speed_back_left, speed_back_right,
        input  ready
    );
    modport sink (
        input  valid, speed_front_left, speed_front_right,
        input  speed_back_left, speed_back_right,
        output ready
    );
endinterface

// ===== rtl/moi_result_if.sv =====
// Result channel of the odometry integrator: velocities, pose and heading.
// Depends on nothing.
interface moi_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] body_vel_x;
    logic signed [15:0] body_vel_y;
    logic signed [15:0] body_rate_z;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] heading;

    modport source (
        output valid, body_vel_x, body_vel_y, body_rate_z, pose_x, pose_y, heading,
        input  ready
    );
    modport sink (
        input  valid, body_vel_x, body_vel_y, body_rate_z, pose_x, pose_y, heading,
        output ready
    );
endinterface

// ===== rtl/moi_mac.sv =====
// Serial arithmetic unit: shift-add multiply-accumulate, one multiplier bit per cycle.
// Depends on moi_pkg.
module moi_mac (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  moi_pkg::t_mac_cmd            i_cmd,
    input  logic signed [moi_pkg::ACC_W-1:0] i_a,
    input  logic [moi_pkg::OPB_W-1:0]    i_b,
    output moi_pkg::t_unit_status        o_status,
    output logic signed [moi_pkg::ACC_W-1:0] o_acc
);

    logic                               r_busy;
    logic                               r_done;
    logic [moi_pkg::CNT_W-1:0]          r_cnt;
    logic                               r_bsig;
    logic                               r_sub;
    logic signed [moi_pkg::ACC_W-1:0]   r_a;
    logic [moi_pkg::OPB_W-1:0]          r_b;
    logic signed [moi_pkg::ACC_W-1:0]   r_acc;

    logic                               last;
    logic                               neg;
    logic signed [moi_pkg::ACC_W-1:0]   addend;
    logic signed [moi_pkg::ACC_W-1:0]   mul_sum;

    // One multiplier bit per cycle, LSB first; the sign bit of a signed
    // operand carries negative weight.
    always_comb begin
        last    = (r_cnt == moi_pkg::CNT_W'(1));
        neg     = r_sub ^ (r_bsig & last);
        addend  = r_b[0] ? (neg ? ~r_a : r_a) : '0;
        mul_sum = r_acc + addend + moi_pkg::ACC_W'(r_b[0] & neg);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - moi_pkg::CNT_W'(1);
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_bsig <= i_cmd.b_signed;
            r_sub  <= i_cmd.sub;
            r_a    <= i_a;
            r_b    <= i_b;
            if (!i_cmd.keep) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            r_acc <= mul_sum;
            r_a   <= r_a <<< 1;
            r_b   <= r_b >> 1;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_acc         = r_acc;

endmodule

// ===== rtl/moi_cordic.sv =====
// Iterative rotation-mode CORDIC: cosine and sine (Q2.30) of a binary angle.
// Depends on moi_pkg.
module moi_cordic (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [31:0]           i_angle,
    output moi_pkg::t_unit_status o_status,
    output logic signed [31:0]    o_cos,
    output logic signed [31:0]    o_sin
);

    logic               r_busy;
    logic               r_done;
    logic [3:0]         r_step;
    logic               r_flip;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [33:0] r_z;

    logic [1:0]         quad;
    logic               flip;
    logic [31:0]        ang;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] atan;

    // Fold quadrants two and three by a half turn; one rotation step per cycle.
    always_comb begin
        quad = i_angle[31:30];
        flip = (quad == 2'b01) || (quad == 2'b10);
        ang  = {i_angle[31] ^ flip, i_angle[30:0]};
        xs   = r_x >>> r_step;
        ys   = r_y >>> r_step;
        atan = signed'({2'b00, moi_pkg::atan_entry(r_step)});
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 4'd1;
                if (r_step == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Rotation datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_flip <= flip;
            r_x    <= moi_pkg::CORDIC_START;
            r_y    <= '0;
            r_z    <= signed'({{2{ang[31]}}, ang});
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan;
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_cos = r_flip ? 32'(-r_x) : r_x[31:0];
    assign o_sin = r_flip ? 32'(-r_y) : r_y[31:0];

endmodule

// ===== rtl/mecanum_odometry_integrator_core.sv =====
// Mecanum odometry integrator: wheel speeds to body velocity, heading and pose.
// Each transaction runs through the bit-serial multiply unit (one operand bit per
// cycle, division by 1000 as a reciprocal multiply) and 16 CORDIC steps. Input is
// taken only in idle, after the last result went to the output register; the next
// input is taken while a result waits. Synchronous active-low reset clears heading and
// pose and loads register defaults. Depends on moi_pkg, the interfaces and the units.
module mecanum_odometry_integrator_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    moi_item_if.sink            i_item,
    moi_result_if.source        o_res
);

    moi_pkg::t_state    r_state;
    moi_pkg::t_state    n_state;
    logic               r_go;
    logic               n_go;

    logic [15:0]        r_radius;
    logic [15:0]        r_inv_base;
    logic [9:0]         r_period;

    logic signed [15:0] r_fl, r_fr, r_bl, r_br;
    logic signed [23:0] r_vx16;
    logic signed [23:0] r_vy16;
    logic signed [28:0] r_wz16;
    logic signed [39:0] r_t;
    logic signed [26:0] r_g;
    logic signed [31:0] r_cos;
    logic signed [31:0] r_sin;
    logic [31:0]        r_heading;
    logic signed [31:0] r_pos_x;
    logic signed [31:0] r_pos_y;

    logic               r_out_valid;
    logic [15:0]        r_out_vx, r_out_vy, r_out_wz;
    logic [31:0]        r_out_px, r_out_py;
    logic [15:0]        r_out_hd;

    moi_pkg::t_mac_cmd       mac_cmd;
    logic signed [63:0]      mac_a;
    logic [35:0]             mac_b;
    moi_pkg::t_unit_status   mac_st;
    logic signed [63:0]      mac_acc;
    logic                    cor_start;
    moi_pkg::t_unit_status   cor_st;
    logic signed [31:0]      cor_cos;
    logic signed [31:0]      cor_sin;

    logic                    accept;
    logic                    step_done;
    logic                    out_free;
    logic signed [17:0]      s1, s2, s3;
    logic signed [63:0]      t_ext;
    logic [63:0]             dvd;
    logic signed [63:0]      rnd10, rnd22, rnd20, rnd30;
    logic signed [33:0]      delta;
    logic signed [33:0]      pos_sum;
    logic signed [31:0]      pos_sat;
    logic signed [31:0]      pos_old;
    logic signed [31:0]      vx8, vy8, wz8;

    moi_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (mac_cmd),
        .i_a      (mac_a),
        .i_b      (mac_b),
        .o_status (mac_st),
        .o_acc    (mac_acc)
    );

    moi_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (cor_start),
        .i_angle  (r_heading),
        .o_status (cor_st),
        .o_cos    (cor_cos),
        .o_sin    (cor_sin)
    );

    // Handshake and wheel sums.
    always_comb begin
        i_item.ready = (r_state == moi_pkg::ST_IDLE) && i_rst_n;
        accept       = i_item.valid && i_item.ready;
        out_free     = !r_out_valid || o_res.ready;
        s1 = 18'(r_fl) + 18'(r_fr) + 18'(r_bl) + 18'(r_br);
        s2 = -18'(r_fl) + 18'(r_fr) + 18'(r_bl) - 18'(r_br);
        s3 = -18'(r_fl) + 18'(r_fr) - 18'(r_bl) + 18'(r_br);
        t_ext = 64'(r_t);
        dvd = r_t[39] ? 64'(~t_ext + 64'sd501) : 64'(t_ext + 64'sd500);
    end

    // Rounding of unit results and the saturating position update.
    // The quotient by 1000 sits in the top 24 bits of the reciprocal product.
    always_comb begin
        rnd10 = (mac_acc + 64'sd512) >>> 10;
        rnd22 = (mac_acc + 64'sd2097152) >>> 22;
        rnd20 = (mac_acc + 64'sd524288) >>> 20;
        rnd30 = (mac_acc + 64'sd536870912) >>> 30;
        delta = r_t[39] ? -34'(signed'({1'b0, mac_acc[63:40]}))
                        : 34'(signed'({1'b0, mac_acc[63:40]}));
        pos_old = (r_state == moi_pkg::ST_GXD) ? r_pos_x : r_pos_y;
        pos_sum = 34'(pos_old) + delta;
        if (pos_sum > 34'sd2147483647) begin
            pos_sat = 32'h7FFF_FFFF;
        end else if (pos_sum < -34'sd2147483648) begin
            pos_sat = 32'h8000_0000;
        end else begin
            pos_sat = pos_sum[31:0];
        end
        vx8 = 32'((25'(r_vx16) + 25'sd128) >>> 8);
        vy8 = 32'((25'(r_vy16) + 25'sd128) >>> 8);
        wz8 = 32'((30'(r_wz16) + 30'sd128) >>> 8);
    end

    // Sequencer: next state and unit commands.
    always_comb begin
        n_state   = r_state;
        mac_cmd   = '{start: 1'b0, b_signed: 1'b0, sub: 1'b0, keep: 1'b0,
                      nbits: moi_pkg::NB_COEF};
        mac_a     = '0;
        mac_b     = '0;
        cor_start = 1'b0;
        step_done = r_go && ((r_state == moi_pkg::ST_CORD) ? cor_st.done : mac_st.done);
        unique case (r_state)
            moi_pkg::ST_IDLE: begin
                if (accept) n_state = moi_pkg::ST_VX;
            end
            moi_pkg::ST_VX: begin
                mac_a = 64'(s1);
                mac_b = 36'(r_radius);
                if (step_done) n_state = moi_pkg::ST_VY;
            end
            moi_pkg::ST_VY: begin
                mac_a = 64'(s2);
                mac_b = 36'(r_radius);
                if (step_done) n_state = moi_pkg::ST_S3R;
            end
            moi_pkg::ST_S3R: begin
                mac_a = 64'(s3);
                mac_b = 36'(r_radius);
                if (step_done) n_state = moi_pkg::ST_WZ;
            end
            moi_pkg::ST_WZ: begin
                mac_a = t_ext;
                mac_b = 36'(r_inv_base);
                if (step_done) n_state = moi_pkg::ST_WZP;
            end
            moi_pkg::ST_WZP: begin
                mac_a = 64'(r_wz16);
                mac_b = 36'(r_period);
                mac_cmd.nbits = moi_pkg::NB_PERIOD;
                if (step_done) n_state = moi_pkg::ST_DH;
            end
            moi_pkg::ST_DH: begin
                mac_a = t_ext;
                mac_b = 36'(moi_pkg::ANGLE_GAIN);
                mac_cmd.nbits = moi_pkg::NB_GAIN;
                if (step_done) n_state = moi_pkg::ST_CORD;
            end
            moi_pkg::ST_CORD: begin
                cor_start = !r_go;
                if (step_done) n_state = moi_pkg::ST_GXC;
            end
            moi_pkg::ST_GXC: begin
                mac_a = 64'(r_cos);
                mac_b = 36'(r_vx16);
                mac_cmd.b_signed = 1'b1;
                mac_cmd.nbits = moi_pkg::NB_VEL;
                if (step_done) n_state = moi_pkg::ST_GXS;
            end
            moi_pkg::ST_GXS: begin
                mac_a = 64'(r_sin);
                mac_b = 36'(r_vy16);
                mac_cmd.b_signed = 1'b1;
                mac_cmd.sub = 1'b1;
                mac_cmd.keep = 1'b1;
                mac_cmd.nbits = moi_pkg::NB_VEL;
                if (step_done) n_state = moi_pkg::ST_GXP;
            end
            moi_pkg::ST_GXP, moi_pkg::ST_GYP: begin
                mac_a = 64'(r_g);
                mac_b = 36'(r_period);
                mac_cmd.nbits = moi_pkg::NB_PERIOD;
                if (step_done) begin
                    n_state = (r_state == moi_pkg::ST_GXP) ? moi_pkg::ST_GXD
                                                           : moi_pkg::ST_GYD;
                end
            end
            // Divide by 1000: drop three bits, then multiply by the reciprocal of 125.
            moi_pkg::ST_GXD, moi_pkg::ST_GYD: begin
                mac_a = signed'(dvd >> 3);
                mac_b = 36'(moi_pkg::RECIP_125);
                mac_cmd.nbits = moi_pkg::NB_RECIP;
                if (step_done) begin
                    n_state = (r_state == moi_pkg::ST_GXD) ? moi_pkg::ST_GYS
                                                           : moi_pkg::ST_OUT;
                end
            end
            moi_pkg::ST_GYS: begin
                mac_a = 64'(r_sin);
                mac_b = 36'(r_vx16);
                mac_cmd.b_signed = 1'b1;
                mac_cmd.nbits = moi_pkg::NB_VEL;
                if (step_done) n_state = moi_pkg::ST_GYC;
            end
            moi_pkg::ST_GYC: begin
                mac_a = 64'(r_cos);
                mac_b = 36'(r_vy16);
                mac_cmd.b_signed = 1'b1;
                mac_cmd.keep = 1'b1;
                mac_cmd.nbits = moi_pkg::NB_VEL;
                if (step_done) n_state = moi_pkg::ST_GYP;
            end
            moi_pkg::ST_OUT: begin
                if (out_free) n_state = moi_pkg::ST_IDLE;
            end
            default: n_state = moi_pkg::ST_IDLE;
        endcase
        mac_cmd.start = !r_go && (r_state != moi_pkg::ST_IDLE) &&
                        (r_state != moi_pkg::ST_OUT) && (r_state != moi_pkg::ST_CORD);
        if (r_state == moi_pkg::ST_IDLE || r_state == moi_pkg::ST_OUT) begin
            n_go = 1'b0;
        end else begin
            n_go = r_go ? !step_done : 1'b1;
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= moi_pkg::ST_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
        end
    end

    // Configuration registers, integration state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= 16'd3277;
            r_inv_base  <= 16'd16384;
            r_period    <= 10'd50;
            r_heading   <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    moi_pkg::CFG_RADIUS:   r_radius   <= i_cfg_data;
                    moi_pkg::CFG_INV_BASE: r_inv_base <= i_cfg_data;
                    moi_pkg::CFG_PERIOD:   r_period   <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (step_done && r_state == moi_pkg::ST_DH) begin
                r_heading <= r_heading + rnd20[31:0];
            end
            if (step_done && r_state == moi_pkg::ST_GXD) begin
                r_pos_x <= pos_sat;
            end
            if (step_done && r_state == moi_pkg::ST_GYD) begin
                r_pos_y <= pos_sat;
            end
            if (r_state == moi_pkg::ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of one transaction.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fl <= i_item.speed_front_left;
            r_fr <= i_item.speed_front_right;
            r_bl <= i_item.speed_back_left;
            r_br <= i_item.speed_back_right;
        end
        if (step_done) begin
            unique case (r_state)
                moi_pkg::ST_VX:   r_vx16 <= rnd10[23:0];
                moi_pkg::ST_VY:   r_vy16 <= rnd10[23:0];
                moi_pkg::ST_S3R:  r_t    <= mac_acc[39:0];
                moi_pkg::ST_WZ:   r_wz16 <= rnd22[28:0];
                moi_pkg::ST_WZP:  r_t    <= mac_acc[39:0];
                moi_pkg::ST_CORD: begin
                    r_cos <= cor_cos;
                    r_sin <= cor_sin;
                end
                moi_pkg::ST_GXS, moi_pkg::ST_GYC: r_g <= rnd30[26:0];
                moi_pkg::ST_GXP, moi_pkg::ST_GYP: r_t <= mac_acc[39:0];
                default: ;
            endcase
        end
        if (r_state == moi_pkg::ST_OUT && out_free) begin
            r_out_vx <= moi_pkg::sat16(vx8);
            r_out_vy <= moi_pkg::sat16(vy8);
            r_out_wz <= moi_pkg::sat16(wz8);
            r_out_px <= r_pos_x;
            r_out_py <= r_pos_y;
            r_out_hd <= r_heading[31:16];
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.body_vel_x  = r_out_vx;
    assign o_res.body_vel_y  = r_out_vy;
    assign o_res.body_rate_z = r_out_wz;
    assign o_res.pose_x      = r_out_px;
    assign o_res.pose_y      = r_out_py;
    assign o_res.heading     = r_out_hd;

    // The serial unit is never restarted while it is still working.
    a_mac_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_cmd.start |-> !mac_st.busy)
        else $error("multiply unit restarted while busy");

    // A multiply completion only arrives while the sequencer waits on it.
    a_mac_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_st.done |-> r_go && (r_state != moi_pkg::ST_CORD))
        else $error("unexpected multiply unit completion");

    // A CORDIC completion only arrives in the rotation step.
    a_cordic_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_st.done |-> r_go && (r_state == moi_pkg::ST_CORD))
        else $error("unexpected CORDIC completion");

    // With a zero period the heading does not move.
    a_zero_period_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_done && r_state == moi_pkg::ST_DH && r_period == 10'd0)
        |=> r_heading == $past(r_heading))
        else $error("heading moved with zero period");

endmodule
